// File: rtl/core/i2c_register_access_master_macros.svh
// Assertion macros for the I2C register access master.
`ifndef I2C_REGISTER_ACCESS_MASTER_MACROS_SVH
`define I2C_REGISTER_ACCESS_MASTER_MACROS_SVH

`ifndef SYNTHESIS
`define I2CRAM_ASSERT_NOW(label, clk, rst_n, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error("i2cram assertion failed");
`define I2CRAM_ASSERT_NEXT(label, clk, rst_n, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error("i2cram assertion failed");
`else
`define I2CRAM_ASSERT_NOW(label, clk, rst_n, cond, conseq)
`define I2CRAM_ASSERT_NEXT(label, clk, rst_n, cond, conseq)
`endif

`endif

// File: rtl/core/i2cram_pkg.sv
// Shared types and codes for the I2C register access master.
package i2cram_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned ACTION_W = 3;
    localparam int unsigned S_DATA_W = 48;
    localparam int unsigned M_DATA_W = 24;

    localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STATUS = 2'd2;

    localparam logic [ACTION_W-1:0] ACT_NONE      = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_START     = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_STOP      = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_SEND      = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_RECV_NACK = 3'd4;

    localparam logic [BYTE_W-1:0] ST_MASK       = 8'hF8;
    localparam logic [BYTE_W-1:0] ST_START      = 8'h08;
    localparam logic [BYTE_W-1:0] ST_RESTART    = 8'h10;
    localparam logic [BYTE_W-1:0] ST_SLA_W_ACK  = 8'h18;
    localparam logic [BYTE_W-1:0] ST_SLA_W_NACK = 8'h20;
    localparam logic [BYTE_W-1:0] ST_DATA_ACK   = 8'h28;
    localparam logic [BYTE_W-1:0] ST_SLA_R_ACK  = 8'h40;
    localparam logic [BYTE_W-1:0] ST_RX_ACK     = 8'h50;
    localparam logic [BYTE_W-1:0] ST_RX_NACK    = 8'h58;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] chip_addr;
        logic [BYTE_W-1:0] register_address;
        logic [BYTE_W-1:0] write_data;
        logic [BYTE_W-1:0] write_count;
        logic [BYTE_W-1:0] bus_status;
        logic [BYTE_W-1:0] read_byte;
    } t_item;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [BYTE_W-1:0]   tx_byte;
        logic [BYTE_W-1:0]   received_byte;
        logic                busy_res;
        logic                request_accepted;
    } t_res;

endpackage

// File: rtl/core/i2c_register_access_master.sv
// Top level of the I2C register access master sequencer.
//
//  channel  dir  tdata                                       tuser
//  s        in   dev, reg, wdata, count, status, rx (48b)    kind (2b)
//  m        out  tx_byte, received_byte, busy, accepted      action (3b)
//
// One word per cycle while m is not stalled; a word accepted on s is held in the input
// register and loaded into the result register when it advances, which sets m valid.
// Synchronous active-low reset clears the valid flags and the transaction state.
// A stall on m holds the result register; s keeps accepting until both
// registers are full.
module i2c_register_access_master
    import i2cram_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // chip_addr, register_address, write_data, write_count, bus_status, read_byte
    input  logic [S_DATA_W-1:0]   i_s_tdata,
    // kind
    input  logic [KIND_W-1:0]     i_s_tuser,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // tx_byte, received_byte, busy_res, request_accepted, zero pad
    output logic [M_DATA_W-1:0]   o_m_tdata,
    // action
    output logic [ACTION_W-1:0]   o_m_tuser
);

    t_item w_s_item;
    t_item w_item;
    t_res  w_res;
    t_res  w_out;
    logic  w_in_valid;
    logic  w_out_valid;
    logic  w_advance;

    assign w_s_item.kind             = i_s_tuser;
    assign w_s_item.chip_addr        = i_s_tdata[7:0];
    assign w_s_item.register_address = i_s_tdata[15:8];
    assign w_s_item.write_data       = i_s_tdata[23:16];
    assign w_s_item.write_count      = i_s_tdata[31:24];
    assign w_s_item.bus_status       = i_s_tdata[39:32];
    assign w_s_item.read_byte        = i_s_tdata[47:40];

    assign w_advance = w_in_valid && (!w_out_valid || i_m_tready);

    i2cram_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .o_ready   (o_s_tready),
        .i_item    (w_s_item),
        .i_advance (w_advance),
        .o_valid   (w_in_valid),
        .o_item    (w_item)
    );

    i2cram_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_advance),
        .i_item  (w_item),
        .o_res   (w_res)
    );

    i2cram_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_advance),
        .i_res   (w_res),
        .i_ready (i_m_tready),
        .o_valid (w_out_valid),
        .o_res   (w_out)
    );

    assign o_m_tvalid = w_out_valid;
    assign o_m_tuser  = w_out.action;
    assign o_m_tdata  = {6'd0, w_out.request_accepted, w_out.busy_res,
                         w_out.received_byte, w_out.tx_byte};

endmodule

// File: rtl/core/i2cram_in_stage.sv
// Input register for request and status words.
module i2cram_in_stage
    import i2cram_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    input  logic  i_advance,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

// File: rtl/core/i2cram_core.sv
// Transaction state and next-action decode.
module i2cram_core
    import i2cram_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_fire,
    input  t_item i_item,
    output t_res  o_res
);

`include "i2c_register_access_master_macros.svh"

    logic              r_busy;
    logic              r_write_mode;
    logic [BYTE_W-1:0] r_writes_left;
    logic [BYTE_W-1:0] r_slave_address;
    logic [BYTE_W-1:0] r_target_register;
    logic [BYTE_W-1:0] r_data_byte;
    logic [BYTE_W-1:0] r_last_received;

    logic              n_busy;
    logic              n_write_mode;
    logic [BYTE_W-1:0] n_writes_left;
    logic [BYTE_W-1:0] n_slave_address;
    logic [BYTE_W-1:0] n_target_register;
    logic [BYTE_W-1:0] n_data_byte;
    logic [BYTE_W-1:0] n_last_received;
    logic [BYTE_W-1:0] w_status;
    logic              w_is_request;

    assign w_status     = i_item.bus_status & ST_MASK;
    assign w_is_request = (i_item.kind == KIND_WRITE) || (i_item.kind == KIND_READ);

    always_comb begin
        n_busy            = r_busy;
        n_write_mode      = r_write_mode;
        n_writes_left     = r_writes_left;
        n_slave_address   = r_slave_address;
        n_target_register = r_target_register;
        n_data_byte       = r_data_byte;
        n_last_received   = r_last_received;
        o_res.action           = ACT_NONE;
        o_res.tx_byte          = '0;
        o_res.request_accepted = 1'b0;
        if (w_is_request) begin
            if (!r_busy) begin
                n_slave_address   = i_item.chip_addr;
                n_target_register = i_item.register_address;
                if (i_item.kind == KIND_WRITE) begin
                    n_data_byte   = i_item.write_data;
                    n_writes_left = i_item.write_count;
                    n_write_mode  = 1'b1;
                end else begin
                    n_write_mode  = 1'b0;
                end
                n_busy                 = 1'b1;
                o_res.action           = ACT_START;
                o_res.request_accepted = 1'b1;
            end
        end else if (i_item.kind == KIND_STATUS) begin
            case (w_status)
                ST_START: begin
                    o_res.action  = ACT_SEND;
                    o_res.tx_byte = r_slave_address;
                end
                ST_RESTART: begin
                    o_res.action  = ACT_SEND;
                    o_res.tx_byte = r_slave_address + 8'd1;
                end
                ST_SLA_W_ACK: begin
                    o_res.action  = ACT_SEND;
                    o_res.tx_byte = r_target_register;
                end
                ST_SLA_W_NACK: begin
                    o_res.action = ACT_STOP;
                    n_busy       = 1'b0;
                end
                ST_DATA_ACK: begin
                    if (r_write_mode) begin
                        if (r_writes_left == '0) begin
                            o_res.action = ACT_STOP;
                            n_busy       = 1'b0;
                        end else begin
                            o_res.action  = ACT_SEND;
                            o_res.tx_byte = r_data_byte;
                            n_writes_left = r_writes_left - 8'd1;
                        end
                    end else begin
                        o_res.action = ACT_START;
                        n_busy       = 1'b1;
                    end
                end
                ST_SLA_R_ACK: begin
                    o_res.action = ACT_RECV_NACK;
                end
                ST_RX_ACK, ST_RX_NACK: begin
                    n_last_received = i_item.read_byte;
                    o_res.action    = ACT_STOP;
                    n_busy          = 1'b0;
                end
                default: begin
                    o_res.action = ACT_NONE;
                end
            endcase
        end
        o_res.received_byte = n_last_received;
        o_res.busy_res      = n_busy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy            <= 1'b0;
            r_write_mode      <= 1'b1;
            r_writes_left     <= '0;
            r_slave_address   <= '0;
            r_target_register <= '0;
            r_data_byte       <= '0;
            r_last_received   <= '0;
        end else if (i_fire) begin
            r_busy            <= n_busy;
            r_write_mode      <= n_write_mode;
            r_writes_left     <= n_writes_left;
            r_slave_address   <= n_slave_address;
            r_target_register <= n_target_register;
            r_data_byte       <= n_data_byte;
            r_last_received   <= n_last_received;
        end
    end

    `I2CRAM_ASSERT_NEXT(a_accept_sets_busy, i_clk, i_rst_n,
        i_fire && o_res.request_accepted, r_busy)
    `I2CRAM_ASSERT_NEXT(a_idle_holds_state, i_clk, i_rst_n,
        !i_fire, $stable(r_busy) && $stable(r_writes_left))
    `I2CRAM_ASSERT_NOW(a_busy_rejects, i_clk, i_rst_n, i_fire && r_busy && w_is_request,
        !o_res.request_accepted && (o_res.action == ACT_NONE))

endmodule

// File: rtl/core/i2cram_out_reg.sv
// Result register toward the bus engine side.
module i2cram_out_reg
    import i2cram_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_load,
    input  t_res i_res,
    input  logic i_ready,
    output logic o_valid,
    output t_res o_res
);

    logic r_valid;
    t_res r_res;

    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule
